// ----- rtl/ssms_pkg.sv -----
`default_nettype none

package ssms_pkg;

    // Fixed field widths
    localparam int KEY_W      = 16;
    localparam int IDX_W      = 12;
    localparam int SET_SIZE_W = 13;

    // Default geometry (BLOCK_SIZE is a power of two)
    localparam int DEF_CAPACITY   = 4096;
    localparam int DEF_BLOCK_SIZE = 16;

    // Input beat action codes
    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_QUERY = 1'b1
    } t_action;

    // Store control from the sequencer
    typedef struct packed {
        logic we;       // write one entry
        logic row_re;   // read one full row (block)
        logic last_re;  // read both ports of the block-last table
    } t_mem_ctl;

endpackage

`default_nettype wire

// ----- rtl/ssms_if.sv -----
`default_nettype none

// Input item channel
interface ssms_in_if;
    logic                           valid;
    logic                           ready;
    ssms_pkg::t_action              action;
    logic [ssms_pkg::IDX_W-1:0]     entry_index;
    logic [ssms_pkg::KEY_W-1:0]     value;

    modport source (output valid, action, entry_index, value, input ready);
    modport sink   (input valid, action, entry_index, value, output ready);
endinterface

// Result channel
interface ssms_out_if;
    logic valid;
    logic ready;
    logic found;

    modport source (output valid, found, input ready);
    modport sink   (input valid, found, output ready);
endinterface

// Configuration write channel
interface ssms_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ssms_pkg::SET_SIZE_W-1:0]    set_size;

    modport source (output valid, set_size, input ready);
    modport sink   (input valid, set_size, output ready);
endinterface

`default_nettype wire

// ----- rtl/ssms_store.sv -----
`default_nettype none

// Entry store: rows of BLOCK_SIZE entries plus a table of each row's last
// entry. Row port: one read. Last table: two reads.
module ssms_store #(
    parameter int CAPACITY   = ssms_pkg::DEF_CAPACITY,
    parameter int BLOCK_SIZE = ssms_pkg::DEF_BLOCK_SIZE,
    localparam int BLK_W     = $clog2(BLOCK_SIZE),
    localparam int NROWS     = (CAPACITY + BLOCK_SIZE - 1) / BLOCK_SIZE,
    localparam int ROW_W     = (NROWS > 1) ? $clog2(NROWS) : 1
) (
    input  wire logic                                       i_clk,
    input  wire ssms_pkg::t_mem_ctl                         i_ctl,
    input  wire logic [ROW_W-1:0]                           i_wr_row,
    input  wire logic [BLK_W-1:0]                           i_wr_lane,
    input  wire logic [ssms_pkg::KEY_W-1:0]                 i_wr_data,
    input  wire logic [ROW_W-1:0]                           i_row_addr,
    input  wire logic [ROW_W-1:0]                           i_last_addr_a,
    input  wire logic [ROW_W-1:0]                           i_last_addr_b,
    output logic [BLOCK_SIZE-1:0][ssms_pkg::KEY_W-1:0]      o_row_data,
    output logic [ssms_pkg::KEY_W-1:0]                      o_last_a,
    output logic [ssms_pkg::KEY_W-1:0]                      o_last_b
);
    import ssms_pkg::*;

    logic [BLOCK_SIZE-1:0][KEY_W-1:0]   r_rows [NROWS];
    logic [KEY_W-1:0]                   r_last [NROWS];
    logic [BLOCK_SIZE-1:0][KEY_W-1:0]   r_row_q;
    logic [KEY_W-1:0]                   r_last_a_q;
    logic [KEY_W-1:0]                   r_last_b_q;

    // Row memory: lane write, full-row read
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_rows[i_wr_row][i_wr_lane] <= i_wr_data;
        end
        if (i_ctl.row_re) begin
            r_row_q <= r_rows[i_row_addr];
        end
    end

    // Block-last table: written with the row's top lane, two read ports
    always_ff @(posedge i_clk) begin
        if (i_ctl.we && (i_wr_lane == BLK_W'(BLOCK_SIZE - 1))) begin
            r_last[i_wr_row] <= i_wr_data;
        end
        if (i_ctl.last_re) begin
            r_last_a_q <= r_last[i_last_addr_a];
            r_last_b_q <= r_last[i_last_addr_b];
        end
    end

    assign o_row_data = r_row_q;
    assign o_last_a   = r_last_a_q;
    assign o_last_b   = r_last_b_q;

endmodule

`default_nettype wire

// ----- rtl/sorted_set_membership_search.sv -----
// Write beat: stored at the accepting edge; the next beat may follow at once.
// Query: P probe rounds (four-way, binary or final step, each a table read in S_PROBE, then a
// compare in S_EVAL), then, if a row is left, the row compare in S_CMP; below one block, row read then S_CMP.
// 256 full blocks: P = 5; worst is 255 full blocks: P = 7.
// Queries are taken only in S_IDLE, one at a time; a result still waiting holds the next query in S_DONE.
// Reset (synchronous, active low) clears set_size, sequencer and result slot, not the entries.
`default_nettype none

module sorted_set_membership_search #(
    parameter int CAPACITY   = ssms_pkg::DEF_CAPACITY,
    parameter int BLOCK_SIZE = ssms_pkg::DEF_BLOCK_SIZE
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ssms_in_if.sink     i_in,
    ssms_out_if.source  o_out,
    ssms_cfg_if.sink    i_cfg
);
    import ssms_pkg::*;

    localparam int BLK_W = $clog2(BLOCK_SIZE);
    localparam int NROWS = (CAPACITY + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int ROW_W = (NROWS > 1) ? $clog2(NROWS) : 1;
    localparam int CNT_W = $clog2(NROWS + 1);
    localparam int SZ_W  = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_EVAL,
        S_CMP,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        M_SMALL,
        M_BLOCK,
        M_TAIL
    } t_mode;

    t_state             r_state;
    t_mode              r_mode;
    logic [KEY_W-1:0]   r_key;
    logic [SZ_W-1:0]    r_size;
    logic [CNT_W-1:0]   r_base;
    logic [CNT_W-1:0]   r_n;
    logic               r_result;
    logic               r_out_valid;
    logic               r_found;

    t_mem_ctl                           w_ctl;
    logic [ROW_W-1:0]                   w_wr_row;
    logic [ROW_W-1:0]                   w_row_addr;
    logic [ROW_W-1:0]                   w_last_addr_a;
    logic [ROW_W-1:0]                   w_last_addr_b;
    logic [BLOCK_SIZE-1:0][KEY_W-1:0]   w_row_data;
    logic [KEY_W-1:0]                   w_last_a;
    logic [KEY_W-1:0]                   w_last_b;

    logic               w_in_beat;
    logic               w_slot_free;
    logic               w_small;
    logic [CNT_W-1:0]   w_nblk;
    logic [BLK_W-1:0]   w_tail_cnt;
    logic [CNT_W-1:0]   w_q;
    logic [CNT_W-1:0]   w_h;
    logic               w_quad;
    logic               w_bin;
    logic [CNT_W-1:0]   w_addr_a;
    logic [CNT_W-1:0]   w_addr_b;
    logic [CNT_W-1:0]   w_addr_r;
    logic               w_lt_a;
    logic               w_lt_b;
    logic               w_lt_r;
    logic [CNT_W-1:0]   w_lo;
    logic               w_lo_in;
    logic               w_tail_any;
    logic [CNT_W-1:0]   w_row_cnt;
    logic               w_cmp_found;

    // Handshakes
    assign i_in.ready   = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign w_in_beat    = i_in.valid && (r_state == S_IDLE);
    assign w_slot_free  = !r_out_valid || o_out.ready;
    assign o_out.valid  = r_out_valid;
    assign o_out.found  = r_found;

    // Set geometry
    assign w_small    = (32'(r_size) < BLOCK_SIZE);
    assign w_nblk     = CNT_W'(32'(r_size) >> BLK_W);
    assign w_tail_cnt = BLK_W'(32'(r_size) & (BLOCK_SIZE - 1));
    assign w_tail_any = (w_tail_cnt != '0);

    // Probe addresses
    assign w_q      = r_n >> 2;
    assign w_h      = r_n >> 1;
    assign w_quad   = (r_n > CNT_W'(3));
    assign w_bin    = (r_n > CNT_W'(1));
    assign w_addr_b = r_base + (w_q << 1);
    assign w_addr_r = r_base + (w_q << 1) + w_q;

    always_comb begin
        priority if (w_quad) begin
            w_addr_a = r_base + w_q;
        end else if (w_bin) begin
            w_addr_a = r_base + w_h;
        end else begin
            w_addr_a = r_base;
        end
    end

    // Probe compares against the key
    assign w_lt_a  = (w_last_a < r_key);
    assign w_lt_b  = (w_last_b < r_key);
    assign w_lt_r  = (w_row_data[BLOCK_SIZE-1] < r_key);
    assign w_lo    = r_base + CNT_W'(w_lt_a);
    assign w_lo_in = (w_lo < w_nblk);

    // Store control and addresses
    always_comb begin
        w_ctl.we      = w_in_beat && (i_in.action == ACT_WRITE)
                        && (32'(i_in.entry_index) < CAPACITY);
        w_ctl.last_re = (r_state == S_PROBE) && !w_small;
        w_ctl.row_re  = ((r_state == S_PROBE) && (w_small || w_quad))
                        || ((r_state == S_EVAL) && !w_bin && (w_lo_in || w_tail_any));
        w_row_cnt = '0;
        if (r_state == S_PROBE) begin
            w_row_cnt = w_small ? '0 : w_addr_r;
        end else if (r_state == S_EVAL) begin
            w_row_cnt = w_lo_in ? w_lo : w_nblk;
        end
    end

    assign w_wr_row      = ROW_W'(32'(i_in.entry_index) >> BLK_W);
    assign w_row_addr    = ROW_W'(w_row_cnt);
    assign w_last_addr_a = ROW_W'(w_addr_a);
    assign w_last_addr_b = ROW_W'(w_addr_b);

    // Row compare: small set and block look for any match; tail lets the
    // first entry not below the key decide
    always_comb begin
        logic any_eq;
        logic any_eq_masked;
        logic first_hit;
        any_eq        = 1'b0;
        any_eq_masked = 1'b0;
        first_hit     = 1'b0;
        for (int j = 0; j < BLOCK_SIZE; j++) begin
            if (w_row_data[j] == r_key) begin
                any_eq = 1'b1;
            end
            if ((BLK_W'(j) < w_tail_cnt) && (w_row_data[j] == r_key)) begin
                any_eq_masked = 1'b1;
            end
        end
        for (int j = BLOCK_SIZE - 1; j >= 0; j--) begin
            if ((BLK_W'(j) < w_tail_cnt) && (w_row_data[j] >= r_key)) begin
                first_hit = (w_row_data[j] == r_key);
            end
        end
        unique case (r_mode)
            M_SMALL: w_cmp_found = any_eq_masked;
            M_BLOCK: w_cmp_found = any_eq;
            M_TAIL:  w_cmp_found = first_hit;
            default: w_cmp_found = 1'b0;
        endcase
    end

    // Set size register, clamped to capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= '0;
        end else if (i_cfg.valid) begin
            if (32'(i_cfg.set_size) > CAPACITY) begin
                r_size <= SZ_W'(CAPACITY);
            end else begin
                r_size <= SZ_W'(i_cfg.set_size);
            end
        end
    end

    // Search sequencer and result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= M_SMALL;
            r_out_valid <= 1'b0;
        end else begin
            // compare and hold states load the slot themselves
            if (r_out_valid && o_out.ready && (r_state != S_CMP) && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_beat && (i_in.action == ACT_QUERY)) begin
                        r_key   <= i_in.value;
                        r_base  <= '0;
                        r_n     <= w_nblk;
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (w_small) begin
                        r_mode  <= M_SMALL;
                        r_state <= S_CMP;
                    end else begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    priority if (w_quad) begin
                        r_base  <= r_base + (w_lt_a ? w_q : '0) + (w_lt_b ? w_q : '0)
                                   + (w_lt_r ? w_q : '0);
                        r_n     <= r_n - ((w_q << 1) + w_q);
                        r_state <= S_PROBE;
                    end else if (w_bin) begin
                        r_base  <= r_base + (w_lt_a ? w_h : '0);
                        r_n     <= r_n - w_h;
                        r_state <= S_PROBE;
                    end else if (w_lo_in) begin
                        r_mode  <= M_BLOCK;
                        r_state <= S_CMP;
                    end else if (w_tail_any) begin
                        r_mode  <= M_TAIL;
                        r_state <= S_CMP;
                    end else begin
                        r_result <= 1'b0;
                        r_state  <= S_DONE;
                    end
                end
                S_CMP: begin
                    if (w_slot_free) begin
                        r_found     <= w_cmp_found;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_result <= w_cmp_found;
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_slot_free) begin
                        r_found     <= r_result;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    ssms_store #(
        .CAPACITY   (CAPACITY),
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_store (
        .i_clk          (i_clk),
        .i_ctl          (w_ctl),
        .i_wr_row       (w_wr_row),
        .i_wr_lane      (i_in.entry_index[BLK_W-1:0]),
        .i_wr_data      (i_in.value),
        .i_row_addr     (w_row_addr),
        .i_last_addr_a  (w_last_addr_a),
        .i_last_addr_b  (w_last_addr_b),
        .o_row_data     (w_row_data),
        .o_last_a       (w_last_a),
        .o_last_b       (w_last_b)
    );

    // A query beat always starts the probe sequence
    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.action == ACT_QUERY)) |=> (r_state == S_PROBE))
        else $error("query beat did not start a search");

    // The candidate window never runs past the full blocks
    a_window_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_PROBE) && !w_small)
        |-> (((CNT_W+1)'(r_base) + (CNT_W+1)'(r_n)) <= (CNT_W+1)'(w_nblk)))
        else $error("search window beyond full blocks");

    // Evaluation always has at least one candidate block
    a_window_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> (r_n != '0))
        else $error("empty search window during evaluation");

    // A result is only published from a compare or a held result
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (($past(r_state) == S_CMP) || ($past(r_state) == S_DONE)))
        else $error("result published outside compare or hold");

endmodule

`default_nettype wire

// ----- bench/sorted_set_membership_search_tb.sv -----
module sorted_set_membership_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssms_pkg::*;

    localparam int CAP           = DEF_CAPACITY;
    localparam int BLK           = DEF_BLOCK_SIZE;
    localparam int SIZE_MAX_CODE = (1 << SET_SIZE_W) - 1;
    localparam int REFILL_MAX    = 200;       // larger sets reuse what is stored
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 880;
    localparam int BURST_ITEMS   = 200;
    localparam int MAX_PRINTS    = 30;
    localparam int KEY_TRIES     = 32;
    localparam int WHOLE_BLOCKS  = 6;         // inner blocks written whole in the store fill

    typedef enum int {
        FILL_LADDER,     // entry i in [16*i, 16*i+15]: stays sorted store-wide
        FILL_DENSE,      // nondecreasing with duplicates, may saturate at the top
        FILL_SCRAMBLED   // random, unsorted
    } t_fill;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic             found;
    } t_answer;

    logic clk;
    logic rst_n;

    ssms_in_if  in_if ();
    ssms_out_if out_if ();
    ssms_cfg_if cfg_if ();

    sorted_set_membership_search dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Mirror of the store and the set size
    logic [KEY_W-1:0] entry_mem [CAP];
    bit               entry_written [CAP];
    bit               read_gap;      // last search touched a never-written entry
    int unsigned      live_size;
    t_answer          pending_answers [$];

    bit          allow_idle;
    int unsigned n_errors    = 0;
    int unsigned n_writes    = 0;
    int unsigned n_queries   = 0;
    int unsigned n_hits      = 0;
    int unsigned n_cfg       = 0;
    int unsigned cycle_count = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles, %0d answers outstanding",
                     cycle_count, pending_answers.size());
            $display("sorted_set_membership_search_tb NOT OK");
            $finish;
        end
    end

    task automatic flag_mismatch(string what);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // Stored entry; a never-written one reads as zero and marks the search
    function automatic logic [KEY_W-1:0] rd(int unsigned idx);
        if (!entry_written[idx]) begin
            read_gap = 1'b1;
            return '0;
        end
        return entry_mem[idx];
    endfunction

    function automatic logic [KEY_W-1:0] block_last(int unsigned blk);
        return rd((blk + 1) * BLK - 1);
    endfunction

    // Membership answer for the current store and set size
    function automatic logic is_member(logic [KEY_W-1:0] key);
        int unsigned nblk, base, span, q, step, lo, j;
        read_gap = 1'b0;
        // below one block: plain scan
        if (live_size < BLK) begin
            for (j = 0; j < live_size; j++)
                if (rd(j) == key)
                    return 1'b1;
            return 1'b0;
        end
        nblk = live_size / BLK;
        base = 0;
        span = nblk;
        // four-way rounds over the block-last values
        while (span > 3) begin
            q    = span >> 2;
            step = int'(block_last(base + q) < key)
                 + int'(block_last(base + 2 * q) < key)
                 + int'(block_last(base + 3 * q) < key);
            base += step * q;
            span -= 3 * q;
        end
        // binary rounds
        while (span > 1) begin
            q = span >> 1;
            if (block_last(base + q) < key)
                base += q;
            span -= q;
        end
        lo = (block_last(base) < key) ? base + 1 : base;
        // whole-block compare
        if (lo < nblk) begin
            for (j = 0; j < BLK; j++)
                if (rd(lo * BLK + j) == key)
                    return 1'b1;
            return 1'b0;
        end
        // tail: first entry not below the key decides
        for (j = nblk * BLK; j < live_size; j++)
            if (rd(j) >= key)
                return rd(j) == key;
        return 1'b0;
    endfunction

    function automatic logic [KEY_W-1:0] ladder_value(int unsigned idx);
        return KEY_W'(idx * 16 + $urandom_range(0, 15));
    endfunction

    // Keys: stored values, block-last values, neighbors, extremes, noise
    function automatic logic [KEY_W-1:0] raw_key(int unsigned n);
        int unsigned      r;
        logic [KEY_W-1:0] e;
        r = $urandom_range(0, 99);
        if (r < 10)
            return r[0] ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
        if (n == 0 || r < 25)
            return KEY_W'($urandom);
        if (r < 40 && n >= BLK)
            return rd($urandom_range(0, n / BLK - 1) * BLK + BLK - 1);
        e = rd($urandom_range(0, n - 1));
        if (r < 70)
            return e;
        if (r < 85)
            return e + 1'b1;
        return e - 1'b1;
    endfunction

    // Only keys whose search stays on written entries; key zero if no try finds one
    function automatic logic [KEY_W-1:0] pick_key(int unsigned n);
        logic [KEY_W-1:0] k;
        for (int t = 0; t < KEY_TRIES; t++) begin
            k = raw_key(n);
            void'(is_member(k));
            if (!read_gap)
                return k;
        end
        return '0;
    endfunction

    function automatic logic [SET_SIZE_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return SET_SIZE_W'($urandom_range(0, BLK - 1));
        if (r < 65)
            return SET_SIZE_W'($urandom_range(BLK, 80));
        if (r < 80)
            return SET_SIZE_W'($urandom_range(81, REFILL_MAX));
        if (r < 93)
            return SET_SIZE_W'($urandom_range(REFILL_MAX + 1, CAP));
        case ($urandom_range(0, 3))
            0: return SET_SIZE_W'(CAP);
            1: return SET_SIZE_W'(SIZE_MAX_CODE);
            2: return SET_SIZE_W'(CAP - 1);
            default: return SET_SIZE_W'($urandom_range(CAP + 1, SIZE_MAX_CODE));
        endcase
    endfunction

    // One input beat; prediction is updated at the accepting edge
    task automatic send_beat(t_action act, logic [IDX_W-1:0] idx, logic [KEY_W-1:0] val);
        t_answer due;
        if (allow_idle && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_if.valid       <= 1'b1;
        in_if.action      <= act;
        in_if.entry_index <= idx;
        in_if.value       <= val;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        if (act == ACT_WRITE) begin
            entry_mem[idx]     = val;
            entry_written[idx] = 1'b1;
            n_writes++;
        end else begin
            due.key   = val;
            due.found = is_member(val);
            pending_answers.push_back(due);
            n_queries++;
            if (due.found)
                n_hits++;
        end
    endtask

    // Drop valid, wait for all answers, then let the block go quiet
    task automatic settle();
        in_if.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_set_size(logic [SET_SIZE_W-1:0] size_code);
        settle();
        cfg_if.valid    <= 1'b1;
        cfg_if.set_size <= size_code;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
        live_size = (size_code > CAP) ? CAP : size_code;
        n_cfg++;
    endtask

    task automatic fill_prefix(int unsigned n, t_fill how);
        int unsigned j, level, step;
        level = ($urandom_range(0, 3) == 0) ? 65535 - $urandom_range(0, 100)
                                            : $urandom_range(0, 65535);
        for (j = 0; j < n; j++) begin
            case (how)
                FILL_LADDER: send_beat(ACT_WRITE, IDX_W'(j), ladder_value(j));
                FILL_DENSE: begin
                    if (j != 0) begin
                        step  = $urandom_range(0, 3);
                        level = (level + step > 65535) ? 65535 : level + step;
                    end
                    send_beat(ACT_WRITE, IDX_W'(j), KEY_W'(level));
                end
                default: send_beat(ACT_WRITE, IDX_W'(j), KEY_W'($urandom));
            endcase
        end
    endtask

    // Refill a small set, set its size, then query with some stray writes mixed in
    task automatic run_phase(logic [SET_SIZE_W-1:0] size_code, t_fill how, int unsigned n_q);
        int unsigned n, k, r, far;
        n = (size_code > CAP) ? CAP : size_code;
        if (n <= REFILL_MAX)
            fill_prefix(n, how);
        write_set_size(size_code);
        for (k = 0; k < n_q; k++) begin
            r = $urandom_range(0, 99);
            if (r < 5 && n > 0) begin
                send_beat(ACT_WRITE, IDX_W'($urandom_range(0, n - 1)), KEY_W'($urandom));
            end else if (r < 10 && n < CAP) begin
                far = $urandom_range(n, CAP - 1);
                send_beat(ACT_WRITE, IDX_W'(far), ladder_value(far));
            end else begin
                send_beat(ACT_QUERY, IDX_W'($urandom), pick_key(n));
            end
        end
    endtask

    // Reset size of zero, a four-entry set, size limits excluding entries
    task automatic test_reset_and_small_sets();
        send_beat(ACT_QUERY, {IDX_W{1'b1}}, {KEY_W{1'b0}});
        send_beat(ACT_QUERY, {IDX_W{1'b0}}, {KEY_W{1'b1}});
        send_beat(ACT_WRITE, IDX_W'(0), 16'h0000);
        send_beat(ACT_WRITE, IDX_W'(1), 16'h1234);
        send_beat(ACT_WRITE, IDX_W'(2), 16'h8000);
        send_beat(ACT_WRITE, IDX_W'(3), 16'hFFFF);
        send_beat(ACT_WRITE, {IDX_W{1'b1}}, 16'hFFFF);
        write_set_size(SET_SIZE_W'(4));
        send_beat(ACT_QUERY, IDX_W'(0), 16'h0000);
        send_beat(ACT_QUERY, IDX_W'(0), 16'hFFFF);
        send_beat(ACT_QUERY, IDX_W'(0), 16'h8000);
        send_beat(ACT_QUERY, IDX_W'(0), 16'h8001);
        send_beat(ACT_QUERY, IDX_W'(0), 16'h1233);
        send_beat(ACT_QUERY, IDX_W'(0), 16'h1234);
        write_set_size(SET_SIZE_W'(3));
        send_beat(ACT_QUERY, IDX_W'(0), 16'hFFFF);
        send_beat(ACT_QUERY, IDX_W'(0), 16'h8000);
        write_set_size(SET_SIZE_W'(0));
        send_beat(ACT_QUERY, IDX_W'(0), 16'h0000);
    endtask

    // Whole store sorted, full-depth search, oversized size, block edges.
    // Every block's last entry is written, plus the first, the last and a few
    // inner blocks whole; queries keep to searches over written entries.
    task automatic test_full_store();
        int unsigned b, j;
        bit          whole [CAP / BLK];
        whole[0]           = 1'b1;
        whole[CAP / BLK - 1] = 1'b1;
        for (j = 0; j < WHOLE_BLOCKS; j++)
            whole[$urandom_range(1, CAP / BLK - 2)] = 1'b1;
        for (b = 0; b < CAP / BLK; b++) begin
            for (j = b * BLK; j < (b + 1) * BLK; j++) begin
                if (!whole[b] && (j != (b + 1) * BLK - 1))
                    continue;
                if (j == 0)
                    send_beat(ACT_WRITE, IDX_W'(j), {KEY_W{1'b0}});
                else if (j == CAP - 1)
                    send_beat(ACT_WRITE, IDX_W'(j), {KEY_W{1'b1}});
                else
                    send_beat(ACT_WRITE, IDX_W'(j), ladder_value(j));
            end
        end
        run_phase(SET_SIZE_W'(CAP), FILL_LADDER, 40);
        send_beat(ACT_QUERY, IDX_W'(0), {KEY_W{1'b0}});
        send_beat(ACT_QUERY, IDX_W'(0), {KEY_W{1'b1}});
        run_phase(SET_SIZE_W'(SIZE_MAX_CODE), FILL_LADDER, 12);
        run_phase(SET_SIZE_W'(CAP - 1), FILL_LADDER, 15);
        send_beat(ACT_QUERY, IDX_W'(0), entry_mem[CAP - 1]);
        run_phase(SET_SIZE_W'(CAP - BLK + 1), FILL_LADDER, 12);
        run_phase(SET_SIZE_W'(BLK + 1), FILL_LADDER, 10);
        run_phase(SET_SIZE_W'(BLK), FILL_LADDER, 10);
        run_phase(SET_SIZE_W'(BLK - 1), FILL_LADDER, 10);
    endtask

    task automatic run_mixed_phases(int unsigned item_goal);
        int unsigned start, r;
        t_fill       how;
        start = n_writes + n_queries;
        while (n_writes + n_queries - start < item_goal) begin
            r   = $urandom_range(0, 99);
            how = (r < 50) ? FILL_LADDER : (r < 85) ? FILL_DENSE : FILL_SCRAMBLED;
            run_phase(pick_size(), how, $urandom_range(10, 30));
        end
    endtask

    task automatic test_random_sets();
        run_mixed_phases(RANDOM_ITEMS);
    endtask

    // Last stretch with both sides always willing
    task automatic test_back_to_back();
        allow_idle = 1'b0;
        run_mixed_phases(BURST_ITEMS);
    endtask

    // Result side: ready with random stall bursts
    initial begin
        int unsigned hold;
        hold = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold != 0) begin
                hold--;
                out_if.ready <= 1'b0;
            end else if (allow_idle && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(0, 8);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Check each result beat against the oldest pending answer
    always @(posedge clk) begin
        t_answer due;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (pending_answers.size() == 0) begin
                flag_mismatch("result beat with no query outstanding");
            end else begin
                due = pending_answers.pop_front();
                if (out_if.found !== due.found)
                    flag_mismatch($sformatf("key %h: found %b, want %b",
                                            due.key, out_if.found, due.found));
            end
        end
    end

    initial begin
        in_if.valid       <= 1'b0;
        in_if.action      <= ACT_WRITE;
        in_if.entry_index <= '0;
        in_if.value       <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.set_size   <= '0;
        rst_n             <= 1'b0;
        allow_idle = 1'b1;
        live_size  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_and_small_sets();
        test_full_store();
        test_random_sets();
        test_back_to_back();
        settle();

        $display("covered %0d entry writes and %0d queries (%0d hits) over %0d set sizes,",
                 n_writes, n_queries, n_hits, n_cfg);
        $display("from empty and sub-block scans to the full store and oversized sizes");
        if (n_errors == 0) begin
            $display("sorted_set_membership_search_tb OK");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("sorted_set_membership_search_tb NOT OK");
        end
        $finish;
    end

endmodule
